[src/url_fold_hash_base36_defines.svh]
// Assertion macros shared by the datapath and top-level RTL files.
`ifndef URL_FOLD_HASH_BASE36_DEFINES_SVH
`define URL_FOLD_HASH_BASE36_DEFINES_SVH
`ifndef SYNTHESIS
// Checked property, disabled while reset is asserted.
`define UFH_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked property that also holds during reset.
`define UFH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UFH_ASSERT(lbl, clk, rst_n, prop, msg)
`define UFH_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[src/ufh36_pkg.sv]
package ufh36_pkg;

  localparam int LANES        = 20;
  localparam int DASH_SPACING = 4;
  localparam int MAX_RESULTS  = 24;
  localparam int MOD_BASE     = 36;
  localparam int SALT_LEN     = 20;

  localparam int RES_W  = 6;
  localparam int CHAR_W = 7;
  localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int GRP_W  = (DASH_SPACING > 1) ? $clog2(DASH_SPACING) : 1;
  localparam int CNT_W  = $clog2(MAX_RESULTS + 1);

  localparam logic [CHAR_W-1:0] DASH_CHAR  = 7'h2D;
  localparam logic [CHAR_W-1:0] ZERO_CHAR  = 7'h30;
  localparam logic [CHAR_W-1:0] ALPHA_CHAR = 7'h41;

  // Residues mod 36 of the salt characters, one per lane.
  localparam logic [RES_W-1:0] SALT_RES [SALT_LEN] = '{
    6'd32, 6'd3, 6'd2, 6'd31, 6'd34, 6'd33, 6'd2, 6'd31, 6'd9, 6'd0,
    6'd25, 6'd2, 6'd8, 6'd3, 6'd2, 6'd28, 6'd25, 6'd9, 6'd13, 6'd21
  };

  typedef struct packed {
    logic [CHAR_W-1:0] data_byte;
    logic              byte_present;
    logic              end_of_url;
  } ufh36_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] hash_char;
    logic              last_char;
    logic              empty_error;
  } ufh36_out_t;

  typedef struct packed {
    logic accum;
    logic load_err;
    logic start_emit;
    logic emit_step;
    logic clear;
  } ufh36_cmd_t;

  typedef struct packed {
    logic seen;
    logic slot_free;
    logic emit_last;
  } ufh36_sts_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } ufh36_state_e;

  // A 7-bit value reduced mod 36 by a short compare chain.
  function automatic logic [RES_W-1:0] byte_mod36(input logic [CHAR_W-1:0] b);
    logic [CHAR_W-1:0] r;
    if (b >= 7'd108) begin
      r = b - 7'd108;
    end else if (b >= 7'd72) begin
      r = b - 7'd72;
    end else if (b >= 7'd36) begin
      r = b - 7'd36;
    end else begin
      r = b;
    end
    return r[RES_W-1:0];
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [RES_W-1:0] r);
    logic [CHAR_W-1:0] c;
    if (r < 6'd10) begin
      c = ZERO_CHAR + {1'b0, r};
    end else begin
      c = ALPHA_CHAR + {1'b0, r} - 7'd10;
    end
    return c;
  endfunction

endpackage

[src/ufh36_ctrl.sv]
module ufh36_ctrl import ufh36_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       byte_present_i,
  input  logic       end_of_url_i,
  input  ufh36_sts_t sts_i,
  output ufh36_cmd_t cmd_o
);

  ufh36_state_e state_q, state_d;
  logic         in_xfer;
  logic         any_byte;

  // Only meaningful in ST_IDLE, the one state that raises in_ready_o.
  assign in_xfer  = in_valid_i && sts_i.slot_free;
  assign any_byte = sts_i.seen || byte_present_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && end_of_url_i && any_byte) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.slot_free && sts_i.emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        // An end transfer may load the error result, so the output slot must be free.
        in_ready_o       = sts_i.slot_free;
        cmd_o.accum      = in_xfer && byte_present_i;
        cmd_o.start_emit = in_xfer && end_of_url_i && any_byte;
        cmd_o.load_err   = in_xfer && end_of_url_i && !any_byte;
        cmd_o.clear      = in_xfer && end_of_url_i && !any_byte;
      end
      ST_EMIT: begin
        cmd_o.emit_step = sts_i.slot_free;
        cmd_o.clear     = sts_i.slot_free && sts_i.emit_last;
      end
      default: begin
        in_ready_o = 1'b0;
        cmd_o      = '0;
      end
    endcase
  end

endmodule

[src/ufh36_datapath.sv]
`include "url_fold_hash_base36_defines.svh"

module ufh36_datapath import ufh36_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CHAR_W-1:0] data_byte_i,
  input  ufh36_cmd_t        cmd_i,
  output ufh36_sts_t        sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ufh36_out_t        out_data_o
);

  logic [RES_W-1:0]  lanes_q [LANES];
  logic [LANE_W-1:0] lane_idx_q;
  logic              seen_q;

  logic [LANE_W-1:0] emit_lane_q;
  logic [GRP_W-1:0]  grp_q;
  logic              dash_q;
  logic [CNT_W-1:0]  cnt_q;

  logic              out_valid_q;
  ufh36_out_t        out_q;

  logic [LANE_W-1:0] rd_addr;
  logic [RES_W-1:0]  rd_data;
  logic [RES_W:0]    sum;
  logic [RES_W-1:0]  acc_res;
  logic              lane_end;
  logic              grp_end;
  logic              emit_last;
  logic [CNT_W-1:0]  cnt_inc;
  ufh36_out_t        emit_item;

  // Accumulation and readout never overlap, so the lanes share one read port.
  assign rd_addr = cmd_i.emit_step ? emit_lane_q : lane_idx_q;
  assign rd_data = lanes_q[rd_addr];

  assign sum     = {1'b0, rd_data} + {1'b0, byte_mod36(data_byte_i)};
  assign acc_res = (sum >= 7'(MOD_BASE)) ? RES_W'(sum - 7'(MOD_BASE)) : sum[RES_W-1:0];

  assign lane_end  = (emit_lane_q == LANE_W'(LANES - 1));
  assign grp_end   = (grp_q == GRP_W'(DASH_SPACING - 1));
  assign cnt_inc   = cnt_q + 1'b1;
  assign emit_last = (cnt_inc == CNT_W'(MAX_RESULTS)) || (!dash_q && lane_end);

  always_comb begin
    emit_item.hash_char   = dash_q ? DASH_CHAR : digit_char(rd_data);
    emit_item.last_char   = emit_last;
    emit_item.empty_error = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LANES; i++) begin
        lanes_q[i] <= SALT_RES[i];
      end
      lane_idx_q <= '0;
      seen_q     <= 1'b0;
    end else if (cmd_i.clear) begin
      for (int i = 0; i < LANES; i++) begin
        lanes_q[i] <= SALT_RES[i];
      end
      lane_idx_q <= '0;
      seen_q     <= 1'b0;
    end else if (cmd_i.accum) begin
      lanes_q[lane_idx_q] <= acc_res;
      lane_idx_q <= (lane_idx_q == LANE_W'(LANES - 1)) ? '0 : lane_idx_q + 1'b1;
      seen_q     <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_lane_q <= '0;
      grp_q       <= '0;
      dash_q      <= 1'b0;
      cnt_q       <= '0;
    end else if (cmd_i.start_emit) begin
      emit_lane_q <= '0;
      grp_q       <= '0;
      dash_q      <= 1'b0;
      cnt_q       <= '0;
    end else if (cmd_i.emit_step) begin
      cnt_q <= cnt_inc;
      if (dash_q) begin
        dash_q <= 1'b0;
      end else begin
        emit_lane_q <= lane_end ? '0 : emit_lane_q + 1'b1;
        grp_q       <= grp_end ? '0 : grp_q + 1'b1;
        // A dash goes in front of every lane that opens a new group.
        dash_q      <= grp_end && !lane_end;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_err || cmd_i.emit_step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_err) begin
      out_q.hash_char   <= '0;
      out_q.last_char   <= 1'b1;
      out_q.empty_error <= 1'b1;
    end else if (cmd_i.emit_step) begin
      out_q <= emit_item;
    end
  end

  assign sts_o.seen      = seen_q;
  assign sts_o.slot_free = !out_valid_q || out_ready_i;
  assign sts_o.emit_last = emit_last;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `UFH_ASSERT(a_last_clears, clk_i, rst_ni, cmd_i.emit_step && emit_last |=> (lane_idx_q == '0) && !seen_q, "lanes not restored after digest")
  `UFH_ASSERT(a_no_double_dash, clk_i, rst_ni, cmd_i.emit_step && dash_q |=> !dash_q, "two dashes in a row")
  `UFH_ASSERT(a_cnt_bound, clk_i, rst_ni, cmd_i.emit_step |-> (cnt_q < CNT_W'(MAX_RESULTS)), "digest longer than the result limit")
  `UFH_ASSERT(a_err_item, clk_i, rst_ni, cmd_i.load_err |=> out_valid_q && out_q.empty_error && out_q.last_char, "error result not loaded")
  `UFH_ASSERT_ALWAYS(a_lane_range, clk_i, !rst_ni || ((lane_idx_q < LANE_W'(LANES)) && (emit_lane_q < LANE_W'(LANES))), "lane pointer out of range")

endmodule

[src/url_fold_hash_base36.sv]
// Byte transfers: one per cycle while in_ready_o is high, each folded into its lane register.
// End transfer: the block enters ST_EMIT, and the first character is loaded into the output
// register once the slot frees; a digest is 24 results, one per cycle while the slot is free.
// A new input is taken once the last result of a digest has been loaded and its slot frees.
// Reset (rst_ni low, asynchronous) restores every lane to its salt residue at once.

`include "url_fold_hash_base36_defines.svh"

module url_fold_hash_base36 import ufh36_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  ufh36_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output ufh36_out_t out_data_o
);

  ufh36_cmd_t cmd;
  ufh36_sts_t sts;

  ufh36_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .byte_present_i (in_data_i.byte_present),
    .end_of_url_i   (in_data_i.end_of_url),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  ufh36_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_byte_i (in_data_i.data_byte),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  `UFH_ASSERT(a_busy_no_input, clk_i, rst_ni, cmd.emit_step |-> !in_ready_o, "input taken during a digest")
  `UFH_ASSERT(a_one_load, clk_i, rst_ni, !(cmd.load_err && (cmd.start_emit || cmd.emit_step)), "conflicting result loads")

endmodule

[sim/tb_url_fold_hash_base36.sv]
`timescale 1ns / 100ps

module tb_url_fold_hash_base36 import ufh36_pkg::*;;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 30;
  localparam int MAX_PRINTS = 40;
  localparam logic [8*36-1:0] DIGIT_ROM = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

  typedef enum logic [1:0] {
    EXP_PREDICT,
    EXP_NONE,
    EXP_EMPTY_ERR
  } check_e;

  typedef struct packed {
    logic [CHAR_W-1:0] data;
    logic              present;
    logic              eou;
    check_e            mode;
  } dir_row_t;

  localparam ufh36_out_t EMPTY_ERR_RESULT = '{hash_char: 7'd0, last_char: 1'b1,
                                              empty_error: 1'b1};

  // Mod-36 boundaries of the character code sit in the middle of the table.
  localparam int NUM_ROWS = 20;
  localparam dir_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{7'h00, 1'b0, 1'b1, EXP_EMPTY_ERR},
    '{7'h7F, 1'b0, 1'b0, EXP_NONE},
    '{7'h7F, 1'b0, 1'b1, EXP_EMPTY_ERR},
    '{7'h00, 1'b1, 1'b1, EXP_PREDICT},
    '{7'h00, 1'b1, 1'b0, EXP_PREDICT},
    '{7'h7F, 1'b1, 1'b0, EXP_PREDICT},
    '{7'h55, 1'b0, 1'b0, EXP_NONE},
    '{7'h2A, 1'b0, 1'b0, EXP_NONE},
    '{7'h7F, 1'b1, 1'b1, EXP_PREDICT},
    '{7'h01, 1'b1, 1'b0, EXP_PREDICT},
    '{7'h23, 1'b1, 1'b0, EXP_PREDICT},
    '{7'h24, 1'b1, 1'b0, EXP_PREDICT},
    '{7'h47, 1'b1, 1'b0, EXP_PREDICT},
    '{7'h48, 1'b1, 1'b0, EXP_PREDICT},
    '{7'h6B, 1'b1, 1'b0, EXP_PREDICT},
    '{7'h6C, 1'b1, 1'b0, EXP_PREDICT},
    '{7'h7E, 1'b1, 1'b0, EXP_PREDICT},
    '{7'h2A, 1'b1, 1'b0, EXP_PREDICT},
    '{7'h00, 1'b0, 1'b1, EXP_PREDICT},
    '{7'h00, 1'b0, 1'b1, EXP_EMPTY_ERR}
  };

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  ufh36_in_t  in_data_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  ufh36_out_t out_data_o;

  check_e exp_mode = EXP_PREDICT;
  int gap_pct = 0;
  int hold_pct = 0;
  int fail_count = 0;
  int stall_cycles = 0;

  // Predicted lane state of the block.
  logic [RES_W-1:0] lane_acc [LANES];
  int lane_pos;
  bit any_char;
  ufh36_out_t digest_buf [MAX_RESULTS];
  ufh36_out_t pending_chars [$];

  url_fold_hash_base36 dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_lanes();
    for (int i = 0; i < LANES; i++) begin
      lane_acc[i] = SALT_RES[i];
    end
    lane_pos = 0;
    any_char = 1'b0;
  endfunction

  function automatic void queue_result(ufh36_out_t r);
    pending_chars = {pending_chars, r};
  endfunction

  // Folds one transfer into the lanes; fills digest_buf and returns the result count.
  function automatic int fold_transfer(ufh36_in_t it);
    int idx;
    int sum;
    int n;
    n = 0;
    if (it.byte_present) begin
      idx = (lane_pos >= LANES) ? 0 : lane_pos;
      sum = (int'(lane_acc[idx]) + int'(it.data_byte)) % MOD_BASE;
      lane_acc[idx] = sum[RES_W-1:0];
      idx = idx + 1;
      lane_pos = (idx >= LANES) ? 0 : idx;
      any_char = 1'b1;
    end
    if (!it.end_of_url) begin
      return 0;
    end
    if (!any_char) begin
      digest_buf[0] = EMPTY_ERR_RESULT;
      clear_lanes();
      return 1;
    end
    for (int i = 0; i < LANES && n < MAX_RESULTS; i++) begin
      if (i > 0 && (i % DASH_SPACING) == 0) begin
        digest_buf[n] = '{hash_char: DASH_CHAR, last_char: 1'b0, empty_error: 1'b0};
        n++;
        if (n >= MAX_RESULTS) begin
          break;
        end
      end
      digest_buf[n].hash_char = DIGIT_ROM[8*(MOD_BASE-1-int'(lane_acc[i])) +: CHAR_W];
      digest_buf[n].last_char = 1'b0;
      digest_buf[n].empty_error = 1'b0;
      n++;
    end
    digest_buf[n-1].last_char = 1'b1;
    clear_lanes();
    return n;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    if (fail_count <= MAX_PRINTS) begin
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    end
  endtask

  task automatic send_item(input logic [CHAR_W-1:0] d, input logic p, input logic e,
                           input check_e m);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{data_byte: d, byte_present: p, end_of_url: e};
    exp_mode <= m;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_chars.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Mostly whole URLs of random characters, with ignored filler transfers mixed in
  // and now and then an end with no characters.
  task automatic run_urls(input int quota);
    int sent;
    int len;
    bit merge_end;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(99) < 8) begin
        send_item(7'($urandom_range(127)), 1'b0, 1'b1, EXP_PREDICT);
        sent++;
      end else begin
        len = ($urandom_range(99) < 85) ? $urandom_range(24, 1) : $urandom_range(60, 25);
        merge_end = ($urandom_range(1) == 1);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(99) < 10) begin
            send_item(7'($urandom_range(127)), 1'b0, 1'b0, EXP_PREDICT);
            sent++;
          end
          send_item(7'($urandom_range(127)), 1'b1, merge_end && (k == len - 1), EXP_PREDICT);
          sent++;
        end
        if (!merge_end) begin
          send_item(7'($urandom_range(127)), 1'b0, 1'b1, EXP_PREDICT);
          sent++;
        end
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= hold_pct);
  end

  always @(posedge clk_i) begin : xfer_mon
    int n;
    ufh36_out_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        n = fold_transfer(in_data_i);
        case (exp_mode)
          EXP_PREDICT: begin
            for (int k = 0; k < n; k++) begin
              queue_result(digest_buf[k]);
            end
          end
          EXP_EMPTY_ERR: begin
            queue_result(EMPTY_ERR_RESULT);
          end
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_chars.size() == 0) begin
          report_mismatch("result with nothing pending, hash_char", out_data_o.hash_char, 0);
        end else begin
          want = pending_chars.pop_front();
          if (out_data_o.hash_char !== want.hash_char) begin
            report_mismatch("hash_char", out_data_o.hash_char, want.hash_char);
          end
          if (out_data_o.last_char !== want.last_char) begin
            report_mismatch("last_char", out_data_o.last_char, want.last_char);
          end
          if (out_data_o.empty_error !== want.empty_error) begin
            report_mismatch("empty_error", out_data_o.empty_error, want.empty_error);
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    int gap_sched [3];
    int hold_sched [3];
    int quota [3];
    gap_sched = '{16, 81, 0};
    hold_sched = '{81, 16, 0};
    quota = '{125, 125, 125};
    clear_lanes();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_pct = gap_sched[0];
    hold_pct = hold_sched[0];
    for (int r = 0; r < NUM_ROWS; r++) begin
      send_item(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].present, DIRECTED_ROWS[r].eou,
                DIRECTED_ROWS[r].mode);
    end

    // The sender holds off between phases until every pending result has come back.
    for (int ph = 0; ph < 3; ph++) begin
      wait_drained();
      gap_pct = gap_sched[ph];
      hold_pct = hold_sched[ph];
      run_urls(quota[ph]);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_chars.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+src
src/ufh36_pkg.sv
src/ufh36_ctrl.sv
src/ufh36_datapath.sv
src/url_fold_hash_base36.sv
sim/tb_url_fold_hash_base36.sv
